### hdl/subscriber_mask_match_table_macros.svh
// Assertion macros shared by the subscriber match table modules.
`ifndef SUBSCRIBER_MASK_MATCH_TABLE_MACROS_SVH
`define SUBSCRIBER_MASK_MATCH_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SMMT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SMMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/smmt_pkg.sv
// Shared types, codes and defaults of the subscriber match table.
package smmt_pkg;

	localparam int SLOTS_DEF     = 16;
	localparam int ID_BITS_DEF   = 8;
	localparam int MASK_BITS_DEF = 32;

	localparam int CMD_W       = 2;
	localparam int STATUS_W    = 2;
	localparam int COUNT_OUT_W = 5;
	localparam int TAG_W       = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;
	localparam int MAX_SUBS_W  = 5;
	localparam int MAX_SUBS_RST = (SLOTS_DEF < 16) ? SLOTS_DEF : 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_SUBSCRIBE   = 2'd0,
		CMD_UNSUBSCRIBE = 2'd1,
		CMD_PUBLISH     = 2'd2,
		CMD_NOP         = 2'd3
	} smmt_op_t;

	typedef enum logic [STATUS_W-1:0] {
		RES_OK        = 2'd0,
		RES_ALREADY   = 2'd1,
		RES_REJECT    = 2'd2,
		RES_NOT_FOUND = 2'd3
	} smmt_res_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLED    = 2'd0,
		CFG_MAX_SUBS   = 2'd1,
		CFG_MESSAGE_ID = 2'd2,
		CFG_UNUSED     = 2'd3
	} smmt_cfg_idx_t;

	localparam logic KIND_DONE     = 1'b0;
	localparam logic KIND_DELIVERY = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic finish;
	} smmt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic early;
		logic scan_last;
	} smmt_stat_t;

endpackage

### hdl/smmt_ram.sv
// Generic simple dual-port RAM with registered read data.
module smmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                          wr_data,
	input  logic                                      rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hdl/smmt_ctrl.sv
// Controller state machine that sequences one command through the table scan.
`include "subscriber_mask_match_table_macros.svh"

module smmt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  smmt_pkg::smmt_stat_t stat,
	output smmt_pkg::smmt_cmd_t  cmd,
	output logic                 busy
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_FLUSH = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.finish = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = stat.early ? S_DONE : S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_last) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				// The last slot read lands in the datapath in this cycle.
				state_d = S_DONE;
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	`SMMT_ASSERT_NEXT(a_load_leaves_idle, clk, arst_n, cmd.load, state_q != S_IDLE, "accepted command did not leave idle")
	`SMMT_ASSERT_NEXT(a_flush_to_done, clk, arst_n, state_q == S_FLUSH, state_q == S_DONE, "flush not followed by done")
	`SMMT_ASSERT_NEXT(a_done_to_idle, clk, arst_n, state_q == S_DONE, state_q == S_IDLE, "done not followed by idle")

endmodule

### hdl/smmt_dp.sv
// Datapath: slot storage, scan pipeline, table update and result register.
`include "subscriber_mask_match_table_macros.svh"

module smmt_dp #(
	parameter int SLOTS     = smmt_pkg::SLOTS_DEF,
	parameter int ID_BITS   = smmt_pkg::ID_BITS_DEF,
	parameter int MASK_BITS = smmt_pkg::MASK_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  smmt_pkg::smmt_cmd_t                    cmd,
	output smmt_pkg::smmt_stat_t                   stat,
	input  logic [smmt_pkg::CMD_W-1:0]             command,
	input  logic [ID_BITS-1:0]                     subscriber_id,
	input  logic [MASK_BITS-1:0]                   match_mask,
	input  logic                                   has_handler,
	input  logic                                   enabled,
	input  logic [$clog2(SLOTS+1)-1:0]             lim,
	input  logic [smmt_pkg::TAG_W-1:0]             message_id,
	input  logic                                   clear,
	output logic                                   result_valid,
	output logic                                   kind,
	output logic [ID_BITS-1:0]                     target_id,
	output logic [smmt_pkg::TAG_W-1:0]             message_tag,
	output logic [smmt_pkg::STATUS_W-1:0]          status,
	output logic [smmt_pkg::COUNT_OUT_W-1:0]       match_count,
	output logic                                   last
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int RW = ID_BITS + MASK_BITS;

	// Latched command.
	smmt_pkg::smmt_op_t  op_q;
	logic [ID_BITS-1:0]   id_q;
	logic [MASK_BITS-1:0] mask_q;
	logic                 early_q;
	smmt_pkg::smmt_res_t  early_res_q;

	// Scan pointer and the probe stage behind the RAM read.
	logic [AW-1:0] addr_q;
	logic          probe_s1;
	logic [AW-1:0] idx_s1;

	// Scan findings.
	logic          found_q;
	logic [AW-1:0] found_idx_q;
	logic          empty_q;
	logic [AW-1:0] empty_idx_q;
	logic [CW-1:0] hits_q;

	// Table occupancy; a slot that is not valid reads as empty.
	logic [SLOTS-1:0] valid_q;
	logic [CW-1:0]    count_q;

	// Result register.
	logic                               res_valid_q;
	logic                               kind_q;
	logic [ID_BITS-1:0]                 target_q;
	logic [smmt_pkg::TAG_W-1:0]         tag_q;
	smmt_pkg::smmt_res_t                status_q;
	logic [smmt_pkg::COUNT_OUT_W-1:0]   count_out_q;
	logic                               last_q;

	smmt_pkg::smmt_op_t  op_in;
	logic                early;
	smmt_pkg::smmt_res_t early_res;
	smmt_pkg::smmt_res_t res_final;
	logic [RW-1:0]       rd_data;
	logic [ID_BITS-1:0]  rd_owner;
	logic [MASK_BITS-1:0] rd_mask;
	logic                vld_s1;
	logic [ID_BITS-1:0]  owner_s1;
	logic                id_hit;
	logic                deliver;
	logic                commit_sub;
	logic                commit_unsub;

	assign op_in = smmt_pkg::smmt_op_t'(command);

	// Commands that are settled without a scan.
	always_comb begin
		early     = 1'b0;
		early_res = smmt_pkg::RES_REJECT;
		if (!enabled) begin
			early = 1'b1;
		end else begin
			unique case (op_in)
				smmt_pkg::CMD_SUBSCRIBE: begin
					early = (count_q >= lim) || !has_handler;
				end
				smmt_pkg::CMD_UNSUBSCRIBE: begin
					early     = (subscriber_id == '0) || (count_q == '0);
					early_res = smmt_pkg::RES_NOT_FOUND;
				end
				smmt_pkg::CMD_PUBLISH: begin
					early = (count_q == '0);
				end
				default: begin
					early = 1'b1;
				end
			endcase
		end
	end

	assign stat.early     = early;
	assign stat.scan_last = (CW'(addr_q) == (lim - CW'(1)));

	smmt_ram #(
		.WIDTH(RW),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk    (clk),
		.wr_en  (commit_sub),
		.wr_addr(empty_idx_q),
		.wr_data({id_q, mask_q}),
		.rd_en  (cmd.scan),
		.rd_addr(addr_q),
		.rd_data(rd_data)
	);

	assign rd_owner = rd_data[RW-1:MASK_BITS];
	assign rd_mask  = rd_data[MASK_BITS-1:0];
	assign vld_s1   = valid_q[idx_s1];
	assign owner_s1 = vld_s1 ? rd_owner : '0;
	// An id of zero hits an empty slot, as the empty marker does.
	assign id_hit   = (owner_s1 == id_q);
	assign deliver  = probe_s1 && (op_q == smmt_pkg::CMD_PUBLISH) && vld_s1
		&& ((rd_mask & mask_q) != '0);

	assign commit_sub = cmd.finish && !early_q && (op_q == smmt_pkg::CMD_SUBSCRIBE)
		&& !found_q && empty_q;
	assign commit_unsub = cmd.finish && !early_q && (op_q == smmt_pkg::CMD_UNSUBSCRIBE)
		&& found_q;

	always_comb begin
		if (early_q) begin
			res_final = early_res_q;
		end else begin
			unique case (op_q)
				smmt_pkg::CMD_SUBSCRIBE: begin
					res_final = found_q ? smmt_pkg::RES_ALREADY
						: (empty_q ? smmt_pkg::RES_OK : smmt_pkg::RES_REJECT);
				end
				smmt_pkg::CMD_UNSUBSCRIBE: begin
					res_final = found_q ? smmt_pkg::RES_OK : smmt_pkg::RES_NOT_FOUND;
				end
				smmt_pkg::CMD_PUBLISH: begin
					res_final = smmt_pkg::RES_OK;
				end
				default: begin
					res_final = smmt_pkg::RES_REJECT;
				end
			endcase
		end
	end

	// Command payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q        <= op_in;
			id_q        <= subscriber_id;
			mask_q      <= match_mask;
			early_res_q <= early_res;
		end
		idx_s1 <= addr_q;
		if (probe_s1 && id_hit && !found_q) begin
			found_idx_q <= idx_s1;
		end
		if (probe_s1 && !vld_s1 && !empty_q) begin
			empty_idx_q <= idx_s1;
		end
	end

	// Scan control and findings.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q   <= '0;
			probe_s1 <= 1'b0;
			early_q  <= 1'b0;
			found_q  <= 1'b0;
			empty_q  <= 1'b0;
			hits_q   <= '0;
		end else begin
			probe_s1 <= cmd.scan;
			if (cmd.load) begin
				addr_q  <= '0;
				early_q <= early;
				found_q <= 1'b0;
				empty_q <= 1'b0;
				hits_q  <= '0;
			end else begin
				if (cmd.scan) begin
					addr_q <= addr_q + AW'(1);
				end
				if (probe_s1 && id_hit) begin
					found_q <= 1'b1;
				end
				if (probe_s1 && !vld_s1) begin
					empty_q <= 1'b1;
				end
				if (deliver) begin
					hits_q <= hits_q + CW'(1);
				end
			end
		end
	end

	// Occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (commit_sub) begin
			valid_q[empty_idx_q] <= 1'b1;
			count_q              <= count_q + CW'(1);
		end else if (commit_unsub) begin
			valid_q[found_idx_q] <= 1'b0;
			count_q              <= count_q - CW'(1);
		end
	end

	// Result register: deliveries during the scan, the done word at finish.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= deliver || cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (deliver) begin
			kind_q      <= smmt_pkg::KIND_DELIVERY;
			target_q    <= owner_s1;
			tag_q       <= message_id;
			status_q    <= smmt_pkg::RES_OK;
			count_out_q <= '0;
			last_q      <= 1'b0;
		end else if (cmd.finish) begin
			kind_q      <= smmt_pkg::KIND_DONE;
			target_q    <= '0;
			tag_q       <= '0;
			status_q    <= res_final;
			count_out_q <= (!early_q && (op_q == smmt_pkg::CMD_PUBLISH))
				? smmt_pkg::COUNT_OUT_W'(hits_q) : '0;
			last_q      <= 1'b1;
		end
	end

	assign result_valid = res_valid_q;
	assign kind         = kind_q;
	assign target_id    = target_q;
	assign message_tag  = tag_q;
	assign status       = status_q;
	assign match_count  = count_out_q;
	assign last         = last_q;

	`SMMT_ASSERT_IMPLY(a_count_tracks_valid, clk, arst_n, 1'b1, $countones(valid_q) == int'(count_q), "occupancy count differs from valid slots")
	`SMMT_ASSERT_IMPLY(a_count_within_limit, clk, arst_n, 1'b1, count_q <= lim, "occupancy count above the slot limit")
	`SMMT_ASSERT_NEXT(a_finish_gives_last, clk, arst_n, cmd.finish, res_valid_q && last_q, "finish without a final result word")

endmodule

### hdl/subscriber_mask_match_table.sv
// Top level of the subscriber match table: configuration registers and the two halves.
//
// Usage.
// A command word (command, subscriber_id, match_mask, has_handler) is taken at a
// clock edge with start high and busy low. Subscribe, unsubscribe and publish each
// end in one done word with last set; a publish first sends one delivery word for
// every occupied slot whose mask shares a bit with the published mask, in slot order.
// Every result word is shown for exactly one cycle with result_valid high; the
// receiver cannot hold it off, so no word is ever stalled or dropped.
// Sequence. A command that is settled at once (table disabled, unknown command,
// full table, no handler, id zero on unsubscribe, empty table) skips the scan: it
// goes from idle to the done state, which loads its done word into the result
// register. Any other command reads the slot memory through its single read port,
// one slot per cycle over the active slots (max_subscribers clamped to 1..SLOTS),
// then passes the flush and done states, with busy high until it is back in idle.
// Deliveries appear as the scan goes on, ahead of the done word.
// Configuration goes over cfg_valid/cfg_ready with cfg_index and cfg_data; it is
// taken only while busy and start are both low. Writing enabled to zero or writing
// max_subscribers empties the table at once. Reset empties the table, disables it,
// sets max_subscribers to its default and message_id to zero.
module subscriber_mask_match_table #(
	parameter int SLOTS     = smmt_pkg::SLOTS_DEF,
	parameter int ID_BITS   = smmt_pkg::ID_BITS_DEF,
	parameter int MASK_BITS = smmt_pkg::MASK_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [smmt_pkg::CMD_W-1:0]           command,
	input  logic [ID_BITS-1:0]                   subscriber_id,
	input  logic [MASK_BITS-1:0]                 match_mask,
	input  logic                                 has_handler,
	output logic                                 result_valid,
	output logic                                 kind,
	output logic [ID_BITS-1:0]                   target_id,
	output logic [smmt_pkg::TAG_W-1:0]           message_tag,
	output logic [smmt_pkg::STATUS_W-1:0]        status,
	output logic [smmt_pkg::COUNT_OUT_W-1:0]     match_count,
	output logic                                 last,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [smmt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [smmt_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int CW = $clog2(SLOTS + 1);
	// Wide enough for both the slot count and the raw register value.
	localparam int LW = (CW > smmt_pkg::MAX_SUBS_W) ? CW : smmt_pkg::MAX_SUBS_W;
	localparam int MAX_RST = (SLOTS < 16) ? SLOTS : 16;

	logic                             enabled_q;
	logic [smmt_pkg::MAX_SUBS_W-1:0]  max_subs_q;
	logic [smmt_pkg::TAG_W-1:0]       message_id_q;

	logic                    cfg_we;
	logic                    clear;
	logic [LW-1:0]           max_ext;
	logic [CW-1:0]           lim;
	smmt_pkg::smmt_cfg_idx_t cfg_sel;
	smmt_pkg::smmt_cmd_t     cmd;
	smmt_pkg::smmt_stat_t    stat;

	// Configuration writes are only taken between commands, and never at the
	// edge that takes a new command word.
	assign cfg_ready = !busy && !start;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign cfg_sel   = smmt_pkg::smmt_cfg_idx_t'(cfg_index);

	// Disabling the table or changing its size empties every slot.
	assign clear = cfg_we && (((cfg_sel == smmt_pkg::CFG_ENABLED) && !cfg_data[0])
		|| (cfg_sel == smmt_pkg::CFG_MAX_SUBS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q    <= 1'b0;
			max_subs_q   <= smmt_pkg::MAX_SUBS_W'(MAX_RST);
			message_id_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_sel)
				smmt_pkg::CFG_ENABLED: begin
					enabled_q <= cfg_data[0];
				end
				smmt_pkg::CFG_MAX_SUBS: begin
					max_subs_q <= cfg_data[smmt_pkg::MAX_SUBS_W-1:0];
				end
				smmt_pkg::CFG_MESSAGE_ID: begin
					message_id_q <= cfg_data[smmt_pkg::TAG_W-1:0];
				end
				default: begin
					// Indexes past the register list are ignored.
				end
			endcase
		end
	end

	// Active slot count: zero reads as one, anything above SLOTS reads as SLOTS.
	assign max_ext = LW'(max_subs_q);
	always_comb begin
		if (max_subs_q == '0) begin
			lim = CW'(1);
		end else if (max_ext > LW'(SLOTS)) begin
			lim = CW'(SLOTS);
		end else begin
			lim = CW'(max_ext);
		end
	end

	smmt_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	smmt_dp #(
		.SLOTS    (SLOTS),
		.ID_BITS  (ID_BITS),
		.MASK_BITS(MASK_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.command      (command),
		.subscriber_id(subscriber_id),
		.match_mask   (match_mask),
		.has_handler  (has_handler),
		.enabled      (enabled_q),
		.lim          (lim),
		.message_id   (message_id_q),
		.clear        (clear),
		.result_valid (result_valid),
		.kind         (kind),
		.target_id    (target_id),
		.message_tag  (message_tag),
		.status       (status),
		.match_count  (match_count),
		.last         (last)
	);

endmodule

### bench/subscriber_mask_match_table_test.sv
// Self-checking testbench of the subscriber mask match table.
`timescale 1ns / 100ps

module subscriber_mask_match_table_test;

	localparam int SLOTS     = smmt_pkg::SLOTS_DEF;
	localparam int ID_BITS   = smmt_pkg::ID_BITS_DEF;
	localparam int MASK_BITS = smmt_pkg::MASK_BITS_DEF;

	// A quiet stretch this long (no command, result or register word taken) means a hang.
	// The slowest correct gap is an idle burst from hold_off plus one full scan.
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_REPORTS = 10;

	// One expected result word, field for field as the block shows it.
	typedef struct packed {
		logic                                  kind;
		logic [ID_BITS-1:0]                    target_id;
		logic [smmt_pkg::TAG_W-1:0]            message_tag;
		smmt_pkg::smmt_res_t                   status;
		logic [smmt_pkg::COUNT_OUT_W-1:0]      match_count;
		logic                                  last;
	} result_word_t;

	logic                                  clk;
	logic                                  arst_n;
	logic                                  start;
	logic                                  busy;
	logic [smmt_pkg::CMD_W-1:0]            command;
	logic [ID_BITS-1:0]                    subscriber_id;
	logic [MASK_BITS-1:0]                  match_mask;
	logic                                  has_handler;
	logic                                  result_valid;
	logic                                  kind;
	logic [ID_BITS-1:0]                    target_id;
	logic [smmt_pkg::TAG_W-1:0]            message_tag;
	logic [smmt_pkg::STATUS_W-1:0]         status;
	logic [smmt_pkg::COUNT_OUT_W-1:0]      match_count;
	logic                                  last;
	logic                                  cfg_valid;
	logic                                  cfg_ready;
	logic [smmt_pkg::CFG_IDX_W-1:0]        cfg_index;
	logic [smmt_pkg::CFG_DATA_W-1:0]       cfg_data;

	// The testbench's own picture of the subscriber table and the registers.
	logic [ID_BITS-1:0]                    owner_tab [SLOTS];
	logic [MASK_BITS-1:0]                  mask_tab [SLOTS];
	int                                    occupied;
	logic                                  table_enabled;
	logic [smmt_pkg::MAX_SUBS_W-1:0]       max_subs;
	logic [smmt_pkg::TAG_W-1:0]            msg_tag;

	// Words the table still owes us, oldest first.
	result_word_t                          pending_words[$];
	result_word_t                          want;

	int                                    error_count;
	int                                    stall_cycles;
	int                                    commands_sent;
	int                                    deliveries_seen;
	int                                    register_writes;
	int                                    widest_fanout;

	subscriber_mask_match_table u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.subscriber_id (subscriber_id),
		.match_mask    (match_mask),
		.has_handler   (has_handler),
		.result_valid  (result_valid),
		.kind          (kind),
		.target_id     (target_id),
		.message_tag   (message_tag),
		.status        (status),
		.match_count   (match_count),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	function automatic void empty_table();
		int i;
		for (i = 0; i < SLOTS; i++) begin
			owner_tab[i] = '0;
			mask_tab[i]  = '0;
		end
		occupied = 0;
	endfunction

	// The limit register is clamped into 1..SLOTS before it is used.
	function automatic int active_slots();
		if (max_subs == 0)
			return 1;
		if (max_subs > SLOTS)
			return SLOTS;
		return int'(max_subs);
	endfunction

	// First slot in range that holds this id; id zero finds the first empty slot.
	function automatic int find_owner(input logic [ID_BITS-1:0] id);
		int i;
		for (i = 0; i < active_slots(); i++)
			if (owner_tab[i] == id)
				return i;
		return -1;
	endfunction

	function automatic void owe_word(input logic k, input logic [ID_BITS-1:0] id,
			input logic [smmt_pkg::TAG_W-1:0] tag, input smmt_pkg::smmt_res_t st,
			input logic [smmt_pkg::COUNT_OUT_W-1:0] cnt, input logic lst);
		result_word_t w;
		w.kind        = k;
		w.target_id   = id;
		w.message_tag = tag;
		w.status      = st;
		w.match_count = cnt;
		w.last        = lst;
		pending_words.push_back(w);
	endfunction

	function automatic void owe_done(input smmt_pkg::smmt_res_t st, input int cnt);
		owe_word(smmt_pkg::KIND_DONE, '0, '0, st, smmt_pkg::COUNT_OUT_W'(cnt), 1'b1);
	endfunction

	// Applies one accepted command to the table picture and queues the words it causes.
	function automatic void predict_command(input smmt_pkg::smmt_op_t op,
			input logic [ID_BITS-1:0] id, input logic [MASK_BITS-1:0] msk,
			input logic hnd);
		int slot;
		int i;
		int hits;
		commands_sent++;
		if (!table_enabled || op == smmt_pkg::CMD_NOP) begin
			owe_done(smmt_pkg::RES_REJECT, 0);
			return;
		end
		case (op)
			smmt_pkg::CMD_SUBSCRIBE: begin
				if (occupied >= active_slots() || !hnd) begin
					owe_done(smmt_pkg::RES_REJECT, 0);
				end else if (find_owner(id) >= 0) begin
					// An id of zero lands here too, since it matches an empty slot.
					owe_done(smmt_pkg::RES_ALREADY, 0);
				end else begin
					slot = find_owner('0);
					if (slot < 0) begin
						owe_done(smmt_pkg::RES_REJECT, 0);
					end else begin
						owner_tab[slot] = id;
						mask_tab[slot]  = msk;
						occupied++;
						owe_done(smmt_pkg::RES_OK, 0);
					end
				end
			end
			smmt_pkg::CMD_UNSUBSCRIBE: begin
				slot = (id == 0 || occupied == 0) ? -1 : find_owner(id);
				if (slot < 0) begin
					owe_done(smmt_pkg::RES_NOT_FOUND, 0);
				end else begin
					owner_tab[slot] = '0;
					mask_tab[slot]  = '0;
					occupied--;
					owe_done(smmt_pkg::RES_OK, 0);
				end
			end
			default: begin
				if (occupied == 0) begin
					owe_done(smmt_pkg::RES_REJECT, 0);
				end else begin
					hits = 0;
					for (i = 0; i < active_slots(); i++) begin
						if (owner_tab[i] != 0 && (mask_tab[i] & msk) != 0) begin
							owe_word(smmt_pkg::KIND_DELIVERY, owner_tab[i], msg_tag,
								smmt_pkg::RES_OK, '0, 1'b0);
							hits++;
						end
					end
					owe_done(smmt_pkg::RES_OK, hits);
					if (hits > widest_fanout)
						widest_fanout = hits;
				end
			end
		endcase
	endfunction

	function automatic void predict_register(input smmt_pkg::smmt_cfg_idx_t idx,
			input logic [smmt_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			smmt_pkg::CFG_ENABLED: begin
				table_enabled = data[0];
				if (!table_enabled)
					empty_table();
			end
			smmt_pkg::CFG_MAX_SUBS: begin
				max_subs = data[smmt_pkg::MAX_SUBS_W-1:0];
				empty_table();
			end
			smmt_pkg::CFG_MESSAGE_ID: msg_tag = data;
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Driving. Inputs move on the falling edge; handshakes are read on the rising edge.
	// ------------------------------------------------------------------

	// Offers one command word and returns on the edge that takes it. Start stays high,
	// so the next word can follow without a gap; whoever drives next decides.
	task automatic send_command(input smmt_pkg::smmt_op_t op, input logic [ID_BITS-1:0] id,
			input logic [MASK_BITS-1:0] msk, input logic hnd);
		@(negedge clk);
		start         = 1'b1;
		command       = op;
		subscriber_id = id;
		match_mask    = msk;
		has_handler   = hnd;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_command(op, id, msk, hnd);
	endtask

	task automatic hold_off(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start = 1'b0;
		end
	endtask

	// Lowers start and waits until every owed word has come, plus a short settle.
	task automatic drain_results();
		@(negedge clk);
		start = 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Registers are only written with the table idle and nothing owed.
	task automatic write_register(input smmt_pkg::smmt_cfg_idx_t idx,
			input logic [smmt_pkg::CFG_DATA_W-1:0] data);
		drain_results();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		predict_register(idx, data);
		register_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Out of reset the table is disabled, so every command is turned away.
	// The unused register index must change nothing.
	task automatic test_disabled_table();
		write_register(smmt_pkg::CFG_UNUSED, 8'hFF);
		send_command(smmt_pkg::CMD_SUBSCRIBE, 8'h11, 32'hFFFF_FFFF, 1'b1);
		send_command(smmt_pkg::CMD_UNSUBSCRIBE, 8'h11, 32'h0, 1'b1);
		send_command(smmt_pkg::CMD_PUBLISH, 8'h00, 32'hFFFF_FFFF, 1'b0);
		send_command(smmt_pkg::CMD_NOP, 8'hFF, 32'h0, 1'b1);
	endtask

	// Every command and status with the widest ids, masks and tag.
	task automatic test_basic_commands();
		write_register(smmt_pkg::CFG_ENABLED, 8'h01);
		write_register(smmt_pkg::CFG_MESSAGE_ID, 8'hFF);
		write_register(smmt_pkg::CFG_MAX_SUBS, 8'h10);
		send_command(smmt_pkg::CMD_SUBSCRIBE, 8'hFF, 32'hFFFF_FFFF, 1'b1);
		send_command(smmt_pkg::CMD_SUBSCRIBE, 8'hFF, 32'h0000_0001, 1'b1);
		send_command(smmt_pkg::CMD_SUBSCRIBE, 8'h10, 32'h0000_00F0, 1'b0);
		// Id zero looks like an empty slot and is reported as already present.
		send_command(smmt_pkg::CMD_SUBSCRIBE, 8'h00, 32'h1234_5678, 1'b1);
		send_command(smmt_pkg::CMD_SUBSCRIBE, 8'h01, 32'h0000_0001, 1'b1);
		send_command(smmt_pkg::CMD_PUBLISH, 8'h00, 32'h0000_0000, 1'b1);
		send_command(smmt_pkg::CMD_PUBLISH, 8'hA5, 32'hFFFF_FFFF, 1'b0);
		send_command(smmt_pkg::CMD_PUBLISH, 8'h00, 32'h8000_0000, 1'b1);
		send_command(smmt_pkg::CMD_UNSUBSCRIBE, 8'h00, 32'h0, 1'b1);
		send_command(smmt_pkg::CMD_UNSUBSCRIBE, 8'hAA, 32'h0, 1'b1);
		send_command(smmt_pkg::CMD_NOP, 8'h01, 32'hFFFF_FFFF, 1'b1);
		send_command(smmt_pkg::CMD_UNSUBSCRIBE, 8'hFF, 32'h0, 1'b0);
		send_command(smmt_pkg::CMD_UNSUBSCRIBE, 8'h01, 32'hFFFF_FFFF, 1'b1);
		// Nothing left to deliver to: the publish is rejected.
		send_command(smmt_pkg::CMD_PUBLISH, 8'h00, 32'hFFFF_FFFF, 1'b1);
	endtask

	// A limit of zero acts as one slot; clearing the enable bit empties the table.
	task automatic test_limit_and_clear();
		write_register(smmt_pkg::CFG_MAX_SUBS, 8'h00);
		send_command(smmt_pkg::CMD_SUBSCRIBE, 8'h05, 32'h0000_FFFF, 1'b1);
		send_command(smmt_pkg::CMD_SUBSCRIBE, 8'h06, 32'hFFFF_0000, 1'b1);
		send_command(smmt_pkg::CMD_PUBLISH, 8'h00, 32'h0000_0100, 1'b1);
		write_register(smmt_pkg::CFG_ENABLED, 8'hFE);
		write_register(smmt_pkg::CFG_ENABLED, 8'h01);
		send_command(smmt_pkg::CMD_PUBLISH, 8'h00, 32'hFFFF_FFFF, 1'b1);
	endtask

	// Random commands. Ids mostly come from a small pool so subscriptions collide
	// and unsubscribes hit; sub_pct steers how fast the table fills.
	task automatic run_random(input int count, input int sub_pct, input bit with_gaps);
		int n;
		int pick;
		smmt_pkg::smmt_op_t op;
		logic [ID_BITS-1:0] id;
		logic [MASK_BITS-1:0] msk;
		logic hnd;
		for (n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < sub_pct)
				op = smmt_pkg::CMD_SUBSCRIBE;
			else if (pick < sub_pct + 20)
				op = smmt_pkg::CMD_UNSUBSCRIBE;
			else if (pick < 97)
				op = smmt_pkg::CMD_PUBLISH;
			else
				op = smmt_pkg::CMD_NOP;
			case ($urandom_range(9))
				0:       id = '0;
				1:       id = ID_BITS'($urandom_range(255));
				default: id = ID_BITS'($urandom_range(1, 20));
			endcase
			case ($urandom_range(7))
				0:       msk = '0;
				1:       msk = '1;
				2, 3:    msk = 32'h1 << $urandom_range(31);
				default: msk = $urandom;
			endcase
			hnd = ($urandom_range(9) != 0);
			if (with_gaps && $urandom_range(3) == 0)
				hold_off($urandom_range(1, 15));
			if (with_gaps && $urandom_range(39) == 0)
				drain_results();
			send_command(op, id, msk, hnd);
		end
	endtask

	// The full table: limit above SLOTS is clamped, subscribes dominate so all
	// sixteen slots fill and publishes fan out widely.
	task automatic test_random_fill();
		write_register(smmt_pkg::CFG_MAX_SUBS, 8'hFF);
		write_register(smmt_pkg::CFG_MESSAGE_ID,
			smmt_pkg::CFG_DATA_W'($urandom_range(255)));
		run_random(60, 60, 1'b1);
	endtask

	// A tiny table with the upper data bits set; between its two runs the sender stops
	// to let every owed word come out before going on.
	task automatic test_random_small();
		write_register(smmt_pkg::CFG_MAX_SUBS, 8'hE3);
		write_register(smmt_pkg::CFG_MESSAGE_ID, 8'h00);
		run_random(20, 35, 1'b1);
		drain_results();
		run_random(20, 35, 1'b1);
	endtask

	task automatic test_random_disabled();
		write_register(smmt_pkg::CFG_ENABLED, 8'h00);
		run_random(10, 35, 1'b1);
		write_register(smmt_pkg::CFG_ENABLED, 8'h01);
	endtask

	task automatic test_random_mid();
		write_register(smmt_pkg::CFG_MAX_SUBS, 8'h09);
		write_register(smmt_pkg::CFG_MESSAGE_ID,
			smmt_pkg::CFG_DATA_W'($urandom_range(255)));
		run_random(40, 45, 1'b1);
	endtask

	// No gaps at all: commands follow each other as fast as busy allows.
	task automatic test_back_to_back();
		write_register(smmt_pkg::CFG_MAX_SUBS, 8'h10);
		write_register(smmt_pkg::CFG_MESSAGE_ID, 8'h5A);
		run_random(50, 50, 1'b0);
	endtask

	// ------------------------------------------------------------------
	// Checking and watchdog
	// ------------------------------------------------------------------

	// Each result word is compared with the oldest owed word. The receiver can
	// not stall, so every cycle with result_valid high is one word.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles = stall_cycles + 1;
			if (result_valid) begin
				if (pending_words.size() == 0) begin
					if (error_count < MAX_REPORTS)
						$display("%0t: unexpected result word kind %0d id %0d status %0d",
							$time, kind, target_id, status);
					error_count++;
				end else begin
					want = pending_words.pop_front();
					if (kind == smmt_pkg::KIND_DELIVERY)
						deliveries_seen++;
					if (kind !== want.kind || target_id !== want.target_id
							|| message_tag !== want.message_tag
							|| status !== want.status
							|| match_count !== want.match_count
							|| last !== want.last) begin
						if (error_count < MAX_REPORTS) begin
							$display("%0t: result mismatch, expected kind %0d id %0d tag %0d",
								$time, want.kind, want.target_id, want.message_tag);
							$display("    status %0d count %0d last %0d; got kind %0d id %0d",
								want.status, want.match_count, want.last, kind, target_id);
							$display("    tag %0d status %0d count %0d last %0d",
								message_tag, status, match_count, last);
						end
						error_count++;
					end
				end
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: watchdog expired, %0d words still owed",
					$time, pending_words.size());
				$display("subscriber_mask_match_table_test: done, errors");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		start           = 1'b0;
		command         = smmt_pkg::CMD_SUBSCRIBE;
		subscriber_id   = '0;
		match_mask      = '0;
		has_handler     = 1'b0;
		cfg_valid       = 1'b0;
		cfg_index       = smmt_pkg::CFG_ENABLED;
		cfg_data        = '0;
		error_count     = 0;
		stall_cycles    = 0;
		commands_sent   = 0;
		deliveries_seen = 0;
		register_writes = 0;
		widest_fanout   = 0;
		// Register values after reset.
		empty_table();
		table_enabled = 1'b0;
		max_subs      = smmt_pkg::MAX_SUBS_W'(smmt_pkg::MAX_SUBS_RST);
		msg_tag       = '0;

		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_disabled_table();
		test_basic_commands();
		test_limit_and_clear();
		test_random_fill();
		test_random_small();
		test_random_disabled();
		test_random_mid();
		test_back_to_back();

		// Let the last scan finish and make sure nothing extra shows up after it.
		drain_results();
		repeat (SLOTS + 4) @(posedge clk);
		if (pending_words.size() != 0) begin
			$display("%0d result words never arrived", pending_words.size());
			error_count += pending_words.size();
		end

		$display("Covered %0d commands, %0d delivery words and %0d register writes;",
			commands_sent, deliveries_seen, register_writes);
		$display("widest publish fan-out %0d, %0d failures", widest_fanout, error_count);
		if (error_count == 0)
			$display("subscriber_mask_match_table_test: done, clean");
		else
			$display("subscriber_mask_match_table_test: done, errors");
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/smmt_pkg.sv
hdl/smmt_ram.sv
hdl/smmt_ctrl.sv
hdl/smmt_dp.sv
hdl/subscriber_mask_match_table.sv
bench/subscriber_mask_match_table_test.sv
